>>> design/owm_pkg.sv
`default_nettype none

package owm_pkg;

  localparam int CFG_BITS       = 10;
  localparam int CFG_COUNT      = 8;
  localparam int CFG_INDEX_BITS = 4;
  localparam int TIMER_BITS_DEF = 10;

  // Operation codes carried by each tick.
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_RESET_LOW    = 3'd0;
  localparam logic [2:0] REG_RESET_WAIT   = 3'd1;
  localparam logic [2:0] REG_PRESENCE     = 3'd2;
  localparam logic [2:0] REG_EDGE         = 3'd3;
  localparam logic [2:0] REG_WRITE_BIT    = 3'd4;
  localparam logic [2:0] REG_WRITE_RECOV  = 3'd5;
  localparam logic [2:0] REG_READ_RECOV   = 3'd6;
  localparam logic [2:0] REG_BYTE_GAP     = 3'd7;

  typedef logic [CFG_BITS-1:0] cfg_word_t;

  // Reset values in register index order.
  localparam cfg_word_t CFG_RESET [CFG_COUNT] = '{
    10'd480, 10'd400, 10'd70, 10'd2, 10'd50, 10'd45, 10'd70, 10'd10
  };

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] tx_byte;
    logic       bus_level;
  } owm_in_t;

  typedef struct packed {
    logic       pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       device_present;
  } owm_out_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] index;
    cfg_word_t                 value;
  } owm_cfg_t;

endpackage

`default_nettype wire

>>> design/owm_chan_if.sv
`default_nettype none

// Valid/ready channel carrying one payload per transfer.
interface owm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/one_wire_bus_master.sv
// The result for a tick is registered and presented in the cycle after its input transfer.
// Throughput: one tick per clock cycle while rsp.ready holds; the output
// register lets a new tick be taken in the same cycle the previous result is taken.
// Reset (rst, synchronous, active high): idle phase, counters and read/presence
// results cleared, configuration registers back to their default timings.
`default_nettype none

module one_wire_bus_master
  import owm_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  owm_chan_if.sink   req,
  owm_chan_if.source rsp,
  owm_chan_if.sink   cfg
);

  // Width used to compare 10-bit register values against the phase timer.
  localparam int CW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
  localparam logic [CW-1:0] TMAX = CW'((64'd1 << TIMER_BITS) - 64'd1);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_W_REL,
    PH_W_LOW,
    PH_W_BIT,
    PH_W_REC,
    PH_W_GAP,
    PH_R_REL,
    PH_R_LOW,
    PH_R_REC
  } phase_t;

  // Configuration registers.
  cfg_word_t cfg_regs [CFG_COUNT];

  // Protocol state.
  phase_t                phase;
  logic [TIMER_BITS-1:0] phase_timer;
  logic [2:0]            bit_count;
  logic [7:0]            shift_byte;
  logic [7:0]            read_result;
  logic                  presence_flag;

  // Output register.
  logic     out_valid;
  owm_out_t out_data;

  // Next-state values for one tick.
  phase_t                phase_next;
  logic [TIMER_BITS-1:0] phase_timer_next;
  logic [2:0]            bit_count_next;
  logic [7:0]            shift_byte_next;
  logic [7:0]            read_result_next;
  logic                  presence_flag_next;
  owm_out_t              out_data_next;

  logic                  in_xfer;
  phase_t                follow;
  logic [TIMER_BITS-1:0] len;
  logic                  last_tick;

  // A length register of zero acts as one, and anything beyond the timer
  // range saturates at the timer maximum.
  function automatic logic [TIMER_BITS-1:0] eff_len(input cfg_word_t r);
    logic [CW-1:0] ext;
    ext = CW'(r);
    if (ext > TMAX) begin
      ext = TMAX;
    end
    if (ext == '0) begin
      ext = CW'(1);
    end
    return TIMER_BITS'(ext);
  endfunction

  // The output register parts the two sides: a new tick is taken whenever
  // the held result is empty or is being taken in this cycle.
  assign req.ready = !out_valid || rsp.ready;
  assign in_xfer   = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_comb begin
    phase_next         = phase;
    phase_timer_next   = phase_timer;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    read_result_next   = read_result;
    presence_flag_next = presence_flag;
    follow             = PH_IDLE;
    len                = TIMER_BITS'(1);
    last_tick          = 1'b0;
    out_data_next      = '0;

    // A command is only started from idle; commands given while busy are
    // dropped. The accepting tick is already the first microsecond of the
    // command's first phase.
    if (phase == PH_IDLE) begin
      phase_timer_next = '0;
      case (req.data.operation)
        OP_RESET: begin
          phase_next         = PH_RST_LOW;
          presence_flag_next = 1'b0;
        end
        OP_WRITE: begin
          phase_next      = PH_W_REL;
          shift_byte_next = req.data.tx_byte;
          bit_count_next  = '0;
        end
        OP_READ: begin
          phase_next      = PH_R_REL;
          shift_byte_next = '0;
          bit_count_next  = '0;
        end
        default: begin
        end
      endcase
    end

    if (phase_next != PH_IDLE) begin
      out_data_next.busy_res = 1'b1;
      case (phase_next)
        PH_RST_LOW: begin
          out_data_next.pull_low = 1'b1;
          len    = eff_len(cfg_regs[REG_RESET_LOW]);
          follow = PH_RST_WAIT;
        end
        PH_RST_WAIT: begin
          // Presence is sampled once, at the configured offset into the wait.
          len = eff_len(cfg_regs[REG_RESET_WAIT]);
          if (CW'(phase_timer_next) == CW'(cfg_regs[REG_PRESENCE])
              && !req.data.bus_level) begin
            presence_flag_next = 1'b1;
          end
          follow = PH_IDLE;
        end
        PH_W_REL: begin
          len    = eff_len(cfg_regs[REG_EDGE]);
          follow = PH_W_LOW;
        end
        PH_W_LOW: begin
          out_data_next.pull_low = 1'b1;
          len    = eff_len(cfg_regs[REG_EDGE]);
          follow = PH_W_BIT;
        end
        PH_W_BIT: begin
          // A zero bit keeps the line low for the whole bit time.
          out_data_next.pull_low = !shift_byte_next[0];
          len    = eff_len(cfg_regs[REG_WRITE_BIT]);
          follow = PH_W_REC;
        end
        PH_W_REC: begin
          len = eff_len(cfg_regs[REG_WRITE_RECOV]);
          if (bit_count_next == 3'd7) begin
            // A gap of zero skips the gap phase entirely.
            follow = (cfg_regs[REG_BYTE_GAP] != '0) ? PH_W_GAP : PH_IDLE;
          end else begin
            follow = PH_W_REL;
          end
        end
        PH_W_GAP: begin
          len    = eff_len(cfg_regs[REG_BYTE_GAP]);
          follow = PH_IDLE;
        end
        PH_R_REL: begin
          len    = eff_len(cfg_regs[REG_EDGE]);
          follow = PH_R_LOW;
        end
        PH_R_LOW: begin
          out_data_next.pull_low = 1'b1;
          len    = eff_len(cfg_regs[REG_EDGE]);
          follow = PH_R_REC;
        end
        PH_R_REC: begin
          // The line is sampled on the first released tick after the low pulse.
          if (phase_timer_next == '0) begin
            shift_byte_next = {req.data.bus_level, shift_byte_next[7:1]};
          end
          len    = eff_len(cfg_regs[REG_READ_RECOV]);
          follow = (bit_count_next == 3'd7) ? PH_IDLE : PH_R_REL;
        end
        default: begin
          follow = PH_IDLE;
        end
      endcase

      last_tick = ({1'b0, phase_timer_next} + (TIMER_BITS + 1)'(1)) >= {1'b0, len};

      if (last_tick) begin
        if (phase_next == PH_W_REC) begin
          shift_byte_next = {1'b0, shift_byte_next[7:1]};
          bit_count_next  = bit_count_next + 3'd1;
        end else if (phase_next == PH_R_REC) begin
          if (bit_count_next == 3'd7) begin
            read_result_next = shift_byte_next;
          end
          bit_count_next = bit_count_next + 3'd1;
        end
        phase_next             = follow;
        phase_timer_next       = '0;
        out_data_next.done_res = (follow == PH_IDLE);
      end else begin
        phase_timer_next = phase_timer_next + TIMER_BITS'(1);
      end
    end

    out_data_next.rx_byte        = read_result_next;
    out_data_next.device_present = presence_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_COUNT; i++) begin
        cfg_regs[i] <= CFG_RESET[i];
      end
      phase         <= PH_IDLE;
      phase_timer   <= '0;
      bit_count     <= '0;
      shift_byte    <= '0;
      read_result   <= '0;
      presence_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // Writes beyond the last register are dropped.
      if (cfg.valid && cfg.data.index < CFG_INDEX_BITS'(CFG_COUNT)) begin
        cfg_regs[cfg.data.index[2:0]] <= cfg.data.value;
      end
      if (in_xfer) begin
        phase         <= phase_next;
        phase_timer   <= phase_timer_next;
        bit_count     <= bit_count_next;
        shift_byte    <= shift_byte_next;
        read_result   <= read_result_next;
        presence_flag <= presence_flag_next;
        out_valid     <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data <= out_data_next;
    end
  end

`ifndef SYNTHESIS
  // A finishing tick always belongs to an operation.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> out_data.busy_res)
    else $error("done without busy");

  // The master only drives the line while an operation runs.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pull_low |-> out_data.busy_res)
    else $error("bus pulled low while idle");

  // An idle tick without a command leaves the block idle and not busy.
  assert property (@(posedge clk) disable iff (rst)
    in_xfer && phase == PH_IDLE && req.data.operation == OP_NONE
    |=> phase == PH_IDLE && !out_data.busy_res)
    else $error("idle tick started an operation");

  // A finished operation leaves the block idle.
  assert property (@(posedge clk) disable iff (rst)
    in_xfer && out_data_next.done_res |=> phase == PH_IDLE)
    else $error("done without return to idle");
`endif

endmodule

`default_nettype wire
